FILE: hw/rtl/dgcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgcd_pkg: shared types and codes for the directed graph cycle detector
// Request codes, node colour codes and the adjacency store control bundle.
// ----------------------------------------------------------------------------
package dgcd_pkg;

    // Field widths fixed by the item format
    localparam int REQ_W        = 2;
    localparam int NODE_FIELD_W = 9;

    // Node count register reset value
    localparam logic [NODE_FIELD_W-1:0] NODE_COUNT_RESET = 9'd256;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Node colours of the depth-first walk
    localparam logic [1:0] COLOUR_WHITE = 2'd0;
    localparam logic [1:0] COLOUR_GREY  = 2'd1;
    localparam logic [1:0] COLOUR_BLACK = 2'd2;

    // Control bundle for the adjacency store
    typedef struct packed {
        logic wr;   // set one edge bit
        logic rd;   // fetch one row
        logic clr;  // drop all edges
    } adj_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/directed_graph_cycle_detect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// directed_graph_cycle_detect: directed graph loader and cycle checker
// Edges are loaded into an adjacency bit matrix; a check request walks the
// graph depth first with an explicit stack and reports any directed cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: an item is taken on a clock edge with start high and
//   busy low. req_type selects add edge, run check or clear graph.
//   Add: busy stays low, so edges load one per cycle. Edges with
//   an end of zero or above MAX_NODES, and self-loops, are dropped.
//   Clear: no result.
//   Check: busy rises for the walk; the item is delivered as a one-cycle
//   done strobe with has_cycle, and busy falls in that same cycle.
//   Check: the walk covers nodes 1 to n, with n = node_count saturated to
//   MAX_NODES. It tests one neighbor bit per cycle while the bits are
//   clear, and every colour, row or stack lookup is a registered memory
//   read. Configuration: cfg_we writes node_count; the user writes it only
//   while the block is idle, which the block itself does not enforce.
//   Reset: node_count returns to 256 and the graph is empty at once; no
//   clearing pass is needed. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module directed_graph_cycle_detect #(
    parameter int unsigned MAX_NODES = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [dgcd_pkg::NODE_FIELD_W-1:0]     cfg_wdata,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [dgcd_pkg::REQ_W-1:0]            req_type,
    input  wire logic [dgcd_pkg::NODE_FIELD_W-1:0]     edge_from,
    input  wire logic [dgcd_pkg::NODE_FIELD_W-1:0]     edge_to,
    output logic                                       done,
    output logic                                       has_cycle
);

    localparam int NW = $clog2(MAX_NODES + 1);  // node number
    localparam int CW = $clog2(MAX_NODES + 2);  // cursor, up to n + 1
    localparam int SW = $clog2(MAX_NODES);      // stack index

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_OUTER    = 3'd1;
    localparam logic [2:0] ST_OUTER_WT = 3'd2;
    localparam logic [2:0] ST_ROW      = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_COL_WT   = 3'd5;
    localparam logic [2:0] ST_POP_WT   = 3'd6;

    logic [2:0]                         state_reg, state_next;
    logic [dgcd_pkg::NODE_FIELD_W-1:0]  node_count_reg;
    logic [NW-1:0]                      n_reg, n_next;
    logic [CW-1:0]                      s_reg, s_next;
    logic [NW-1:0]                      top_u_reg, top_u_next;
    logic [CW-1:0]                      top_cur_reg, top_cur_next;
    logic [NW-1:0]                      depth_reg, depth_next;
    logic                               done_reg, done_next;
    logic                               has_cycle_reg, has_cycle_next;

    // Colour store
    logic [1:0]     colour_mem [MAX_NODES + 1];
    logic [MAX_NODES:0] col_vld_reg;
    logic           col_we, col_re, col_clr;
    logic [NW-1:0]  col_waddr, col_raddr;
    logic [1:0]     col_wdata;
    logic [1:0]     col_rdata_reg;
    logic           col_rvld_reg;
    logic [1:0]     colour_now;

    // Walk stack
    logic [NW-1:0]  stk_node_mem [MAX_NODES];
    logic [CW-1:0]  stk_cur_mem  [MAX_NODES];
    logic           stk_we, stk_re;
    logic [SW-1:0]  stk_waddr, stk_raddr;
    logic [NW-1:0]  stk_wnode, stk_rnode_reg;
    logic [CW-1:0]  stk_wcur, stk_rcur_reg;

    // Adjacency store
    dgcd_pkg::adj_ctl_t adj_ctl;
    logic [NW-1:0]      adj_rd_row;
    logic [MAX_NODES:0] adj_row;

    logic           edge_ok;
    logic [NW-1:0]  n_sat;
    logic           accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Qualify an edge and saturate the node count
    assign edge_ok = (edge_from != '0) && (edge_to != '0) && (edge_from != edge_to)
                  && (32'(edge_from) <= 32'(MAX_NODES))
                  && (32'(edge_to) <= 32'(MAX_NODES));
    assign n_sat = (32'(node_count_reg) > 32'(MAX_NODES)) ? NW'(MAX_NODES)
                                                         : NW'(node_count_reg);

    assign colour_now = col_rvld_reg ? col_rdata_reg : dgcd_pkg::COLOUR_WHITE;

    dgcd_adj_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (adj_ctl),
        .wr_row  (NW'(edge_from)),
        .wr_col  (NW'(edge_to)),
        .rd_row  (adj_rd_row),
        .rd_data (adj_row)
    );

    // Sequence requests and the depth-first walk
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        top_u_next     = top_u_reg;
        top_cur_next   = top_cur_reg;
        depth_next     = depth_reg;
        done_next      = 1'b0;
        has_cycle_next = has_cycle_reg;
        col_we         = 1'b0;
        col_re         = 1'b0;
        col_clr        = 1'b0;
        col_waddr      = top_u_reg;
        col_raddr      = top_cur_reg[NW-1:0];
        col_wdata      = dgcd_pkg::COLOUR_BLACK;
        stk_we         = 1'b0;
        stk_re         = 1'b0;
        stk_waddr      = SW'(depth_reg - NW'(1));
        stk_raddr      = SW'(depth_reg - NW'(2));
        stk_wnode      = top_u_reg;
        stk_wcur       = top_cur_reg + CW'(1);
        adj_ctl        = '0;
        adj_rd_row     = top_u_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (req_type == dgcd_pkg::REQ_ADD)
                    begin
                        adj_ctl.wr = edge_ok;
                    end
                    else if (req_type == dgcd_pkg::REQ_CHECK)
                    begin
                        n_next     = n_sat;
                        s_next     = CW'(1);
                        depth_next = '0;
                        col_clr    = 1'b1;
                        state_next = ST_OUTER;
                    end
                    else if (req_type == dgcd_pkg::REQ_CLEAR)
                    begin
                        adj_ctl.clr = 1'b1;
                    end
                    else
                    begin
                        // unused code: drop
                    end
                end
            end

            ST_OUTER:
            begin
                if (s_reg > CW'(n_reg))
                begin
                    done_next      = 1'b1;
                    has_cycle_next = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    col_re     = 1'b1;
                    col_raddr  = s_reg[NW-1:0];
                    state_next = ST_OUTER_WT;
                end
            end

            ST_OUTER_WT:
            begin
                if (colour_now != dgcd_pkg::COLOUR_WHITE)
                begin
                    s_next     = s_reg + CW'(1);
                    state_next = ST_OUTER;
                end
                else
                begin
                    col_we       = 1'b1;
                    col_waddr    = s_reg[NW-1:0];
                    col_wdata    = dgcd_pkg::COLOUR_GREY;
                    top_u_next   = s_reg[NW-1:0];
                    top_cur_next = CW'(1);
                    depth_next   = NW'(1);
                    state_next   = ST_ROW;
                end
            end

            ST_ROW:
            begin
                adj_ctl.rd = 1'b1;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (top_cur_reg > CW'(n_reg))
                begin
                    // finish node: blacken and pop
                    col_we     = 1'b1;
                    depth_next = depth_reg - NW'(1);
                    if (depth_reg == NW'(1))
                    begin
                        s_next     = s_reg + CW'(1);
                        state_next = ST_OUTER;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        state_next = ST_POP_WT;
                    end
                end
                else if (adj_row[top_cur_reg[NW-1:0]])
                begin
                    col_re     = 1'b1;
                    state_next = ST_COL_WT;
                end
                else
                begin
                    top_cur_next = top_cur_reg + CW'(1);
                end
            end

            ST_COL_WT:
            begin
                top_cur_next = top_cur_reg + CW'(1);
                priority if (colour_now == dgcd_pkg::COLOUR_GREY)
                begin
                    done_next      = 1'b1;
                    has_cycle_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (colour_now == dgcd_pkg::COLOUR_WHITE)
                begin
                    // push: save parent, descend into neighbor
                    stk_we       = 1'b1;
                    col_we       = 1'b1;
                    col_waddr    = top_cur_reg[NW-1:0];
                    col_wdata    = dgcd_pkg::COLOUR_GREY;
                    top_u_next   = top_cur_reg[NW-1:0];
                    top_cur_next = CW'(1);
                    depth_next   = depth_reg + NW'(1);
                    state_next   = ST_ROW;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_POP_WT:
            begin
                top_u_next   = stk_rnode_reg;
                top_cur_next = stk_rcur_reg;
                state_next   = ST_ROW;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= dgcd_pkg::NODE_COUNT_RESET;
            n_reg          <= '0;
            s_reg          <= '0;
            top_u_reg      <= '0;
            top_cur_reg    <= '0;
            depth_reg      <= '0;
            done_reg       <= 1'b0;
            has_cycle_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            s_reg         <= s_next;
            top_u_reg     <= top_u_next;
            top_cur_reg   <= top_cur_next;
            depth_reg     <= depth_next;
            done_reg      <= done_next;
            has_cycle_reg <= has_cycle_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    // Colour store: valid flags make every node white at check start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_vld_reg  <= '0;
            col_rvld_reg <= 1'b0;
        end
        else
        begin
            if (col_clr)
            begin
                col_vld_reg <= '0;
            end
            else if (col_we)
            begin
                col_vld_reg[col_waddr] <= 1'b1;
            end
            if (col_re)
            begin
                col_rvld_reg <= col_vld_reg[col_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            colour_mem[col_waddr] <= col_wdata;
        end
        if (col_re)
        begin
            col_rdata_reg <= colour_mem[col_raddr];
        end
    end

    // Walk stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_node_mem[stk_waddr] <= stk_wnode;
            stk_cur_mem[stk_waddr]  <= stk_wcur;
        end
        if (stk_re)
        begin
            stk_rnode_reg <= stk_node_mem[stk_raddr];
            stk_rcur_reg  <= stk_cur_mem[stk_raddr];
        end
    end

    assign done      = done_reg;
    assign has_cycle = has_cycle_reg;

    // Checks
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_OUTER || $past(state_reg) == ST_COL_WT))
        else $error("result strobe without a finished walk");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy still high with result strobe");

    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == dgcd_pkg::REQ_CHECK) |=> busy)
        else $error("check accepted but walk not started");

    a_scan_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_ROW) |-> (depth_reg != '0))
        else $error("walk running with empty stack");

    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= NW'(MAX_NODES))
        else $error("stack depth above node limit");

endmodule
`default_nettype wire

FILE: hw/rtl/dgcd_adj_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgcd_adj_mem: adjacency bit matrix of the cycle detector
// One row per source node, one bit per target node. Each row has a valid
// flag so that reset and clear empty the whole matrix by dropping the flags; a row
// that is not valid reads as all zeros and is rewritten whole on first add.
// ----------------------------------------------------------------------------
module dgcd_adj_mem #(
    parameter int unsigned MAX_NODES = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dgcd_pkg::adj_ctl_t                  ctl,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]      wr_row,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]      wr_col,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]      rd_row,
    output logic      [MAX_NODES:0]                  rd_data
);

    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int ROW_W = MAX_NODES + 1;

    logic [ROW_W-1:0] mem [ROW_W];
    logic [ROW_W-1:0] row_vld_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_vld_reg;

    // Set one edge bit; a fresh row is written whole so stale bits drop
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            for (int i = 0; i < ROW_W; i++)
            begin
                if (!row_vld_reg[wr_row] || (NW'(i) == wr_col))
                begin
                    mem[wr_row][i] <= (NW'(i) == wr_col);
                end
            end
        end
    end

    // Hold row valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (ctl.clr)
        begin
            row_vld_reg <= '0;
        end
        else if (ctl.wr)
        begin
            row_vld_reg[wr_row] <= 1'b1;
        end
    end

    // Fetch one row, registered
    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (ctl.rd)
        begin
            rd_vld_reg <= row_vld_reg[rd_row];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

FILE: tb/sv/directed_graph_cycle_detect_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// directed_graph_cycle_detect_test: self-checking bench for the cycle detector
// Loads edge sets under several node counts, runs cycle checks and compares
// each has_cycle strobe with an in-bench depth-first walk of the same graph.
// Directed corner items come first, then random graphs with random gaps.
// ----------------------------------------------------------------------------
module directed_graph_cycle_detect_test;

    typedef logic [dgcd_pkg::NODE_FIELD_W-1:0] node_field_t;
    typedef logic [dgcd_pkg::REQ_W-1:0]        req_field_t;

    localparam int unsigned GRAPH_NODES   = 256;
    localparam int unsigned ITEM_TARGET   = 1550;
    localparam int unsigned STALL_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam req_field_t  REQ_UNUSED    = 2'd3;

    // ------------------------------------------------------------------------
    // Graph scoreboard: shadow graph, node count and pending check answers
    // ------------------------------------------------------------------------
    class graph_scoreboard;
        bit [GRAPH_NODES:0]                adj_rows [0:GRAPH_NODES];
        bit [1:0]                          colour [0:GRAPH_NODES];
        int unsigned                       walk_node [0:GRAPH_NODES];
        int unsigned                       walk_next [0:GRAPH_NODES];
        bit [dgcd_pkg::NODE_FIELD_W-1:0]   node_count;
        bit                                cycle_answers [$];
        int unsigned                       errors;

        function new();
            node_count = dgcd_pkg::NODE_COUNT_RESET;
            errors = 0;
            drop_edges();
        endfunction

        function void drop_edges();
            foreach (adj_rows[i])
                adj_rows[i] = '0;
        endfunction

        function int unsigned pending();
            return cycle_answers.size();
        endfunction

        // Three-colour depth-first walk over nodes 1..n with an explicit stack
        function bit graph_has_cycle();
            int unsigned n;
            int unsigned s;
            int unsigned depth;
            int unsigned top;
            int unsigned u;
            int unsigned v;
            n = (node_count > GRAPH_NODES) ? GRAPH_NODES : node_count;
            foreach (colour[i])
                colour[i] = dgcd_pkg::COLOUR_WHITE;
            for (s = 1; s <= n; s++)
            begin
                if (colour[s] != dgcd_pkg::COLOUR_WHITE)
                    continue;
                colour[s] = dgcd_pkg::COLOUR_GREY;
                walk_node[0] = s;
                walk_next[0] = 1;
                depth = 1;
                while (depth > 0)
                begin
                    top = depth - 1;
                    u = walk_node[top];
                    v = walk_next[top];
                    while (v <= n && !adj_rows[u][v])
                        v++;
                    // no neighbor left: retire the node
                    if (v > n)
                    begin
                        colour[u] = dgcd_pkg::COLOUR_BLACK;
                        depth--;
                        continue;
                    end
                    walk_next[top] = v + 1;
                    if (colour[v] == dgcd_pkg::COLOUR_GREY)
                        return 1'b1;
                    if (colour[v] == dgcd_pkg::COLOUR_WHITE)
                    begin
                        colour[v] = dgcd_pkg::COLOUR_GREY;
                        walk_node[depth] = v;
                        walk_next[depth] = 1;
                        depth++;
                    end
                end
            end
            return 1'b0;
        endfunction

        // Apply one accepted item to the shadow graph
        function void accept_item(bit [dgcd_pkg::REQ_W-1:0] req,
                                  bit [dgcd_pkg::NODE_FIELD_W-1:0] from_node,
                                  bit [dgcd_pkg::NODE_FIELD_W-1:0] to_node);
            case (req)
                dgcd_pkg::REQ_ADD:
                begin
                    if (from_node != 0 && to_node != 0 && from_node != to_node &&
                        from_node <= GRAPH_NODES && to_node <= GRAPH_NODES)
                        adj_rows[from_node][to_node] = 1'b1;
                end
                dgcd_pkg::REQ_CHECK: cycle_answers.push_back(graph_has_cycle());
                dgcd_pkg::REQ_CLEAR: drop_edges();
                default: ;
            endcase
        endfunction

        // Compare one has_cycle strobe with the oldest pending answer
        function void compare_result(logic got);
            bit want;
            if (cycle_answers.size() == 0)
            begin
                $error("has_cycle: result with no check pending, actual %0b", got);
                errors++;
                return;
            end
            want = cycle_answers.pop_front();
            if (got !== want)
            begin
                $error("has_cycle: expected %0b, actual %0b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    node_field_t cfg_wdata;
    logic        start;
    logic        busy;
    req_field_t  req_type;
    node_field_t edge_from;
    node_field_t edge_to;
    logic        done;
    logic        has_cycle;

    graph_scoreboard sb;
    int unsigned     items_sent;
    int unsigned     stall_cycles;

    directed_graph_cycle_detect #(
        .MAX_NODES (GRAPH_NODES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .edge_from (edge_from),
        .edge_to   (edge_to),
        .done      (done),
        .has_cycle (has_cycle)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Check every result strobe
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.compare_result(has_cycle);
    end

    // Watchdog: count cycles with no item or result accepted
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("directed_graph_cycle_detect_test: FAIL");
            $finish;
        end
    end

    // Gap length: mostly none or short, a few long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random 9-bit node field, including values out of range
    function automatic node_field_t rand_node();
        return node_field_t'($urandom_range(0, 511));
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(input req_field_t req,
                             input node_field_t from_node,
                             input node_field_t to_node);
        @(negedge clk);
        start = 1'b1;
        req_type = req;
        edge_from = from_node;
        edge_to = to_node;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.accept_item(req, from_node, to_node);
        items_sent++;
    endtask

    // Drop start for a random number of cycles, with noise on the fields
    task automatic sender_gap();
        int unsigned len;
        len = gap_len();
        repeat (len)
        begin
            @(negedge clk);
            start = 1'b0;
            req_type = req_field_t'($urandom_range(0, 3));
            edge_from = rand_node();
            edge_to = rand_node();
        end
    endtask

    // Hold off until every pending check has answered and the block is idle
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write node_count while idle
    task automatic set_node_count(input node_field_t value);
        drain_results();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sb.node_count = value;
    endtask

    // Stimulus
    initial
    begin
        int unsigned  phase_idx;
        int unsigned  n;
        int unsigned  loads;
        int unsigned  r;
        bit           steady;
        bit           acyclic;
        node_field_t  a;
        node_field_t  b;
        node_field_t  t;

        sb = new();
        items_sent = 0;
        stall_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        start = 1'b0;
        req_type = dgcd_pkg::REQ_ADD;
        edge_from = '0;
        edge_to = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full node count: dropped edges, out-of-range ends, unused code
        set_node_count(9'd256);
        send_item(dgcd_pkg::REQ_ADD, 9'd0, 9'd5);
        send_item(dgcd_pkg::REQ_ADD, 9'd5, 9'd0);
        send_item(dgcd_pkg::REQ_ADD, 9'd7, 9'd7);
        send_item(dgcd_pkg::REQ_ADD, 9'd257, 9'd3);
        send_item(dgcd_pkg::REQ_ADD, 9'd3, 9'd257);
        send_item(dgcd_pkg::REQ_ADD, 9'd511, 9'd511);
        send_item(dgcd_pkg::REQ_ADD, 9'd256, 9'd1);
        send_item(dgcd_pkg::REQ_ADD, 9'd1, 9'd256);
        send_item(REQ_UNUSED, 9'd2, 9'd1);
        send_item(dgcd_pkg::REQ_CHECK, 9'd511, 9'd511);
        send_item(dgcd_pkg::REQ_CLEAR, 9'd0, 9'd0);
        send_item(dgcd_pkg::REQ_CHECK, 9'd0, 9'd0);

        // Small node count: stored edges beyond it are skipped by the walk
        set_node_count(9'd4);
        send_item(dgcd_pkg::REQ_ADD, 9'd4, 9'd200);
        send_item(dgcd_pkg::REQ_ADD, 9'd200, 9'd4);
        send_item(dgcd_pkg::REQ_CHECK, 9'd0, 9'd0);
        send_item(dgcd_pkg::REQ_ADD, 9'd1, 9'd2);
        send_item(dgcd_pkg::REQ_ADD, 9'd2, 9'd3);
        send_item(dgcd_pkg::REQ_ADD, 9'd3, 9'd4);
        send_item(dgcd_pkg::REQ_ADD, 9'd4, 9'd1);
        send_item(dgcd_pkg::REQ_CHECK, 9'd0, 9'd0);

        // Zero nodes, saturated count and a single node
        set_node_count(9'd0);
        send_item(dgcd_pkg::REQ_CHECK, 9'd0, 9'd0);
        set_node_count(9'd511);
        send_item(dgcd_pkg::REQ_CHECK, 9'd0, 9'd0);
        set_node_count(9'd1);
        send_item(dgcd_pkg::REQ_CHECK, 9'd0, 9'd0);

        // Random graphs, one node count per phase
        phase_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            phase_idx++;
            if (phase_idx == 20)
                n = GRAPH_NODES;
            else if ($urandom_range(0, 7) == 0)
                n = $urandom_range(13, 40);
            else
                n = $urandom_range(1, 12);
            set_node_count(node_field_t'(n));
            steady = ($urandom_range(0, 3) == 0);
            acyclic = $urandom_range(0, 1);
            if ($urandom_range(0, 9) < 7)
                send_item(dgcd_pkg::REQ_CLEAR, rand_node(), rand_node());
            loads = $urandom_range(0, (3 * n + 2 > 40) ? 40 : 3 * n + 2);
            repeat (loads)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send_item(dgcd_pkg::REQ_ADD, rand_node(), rand_node());
                else if (r < 11)
                    send_item(REQ_UNUSED, rand_node(), rand_node());
                else if (r < 14 && n < GRAPH_NODES)
                begin
                    // one end above node_count, still a stored edge
                    a = node_field_t'($urandom_range(n + 1, GRAPH_NODES));
                    b = node_field_t'($urandom_range(1, n));
                    if ($urandom_range(0, 1))
                        send_item(dgcd_pkg::REQ_ADD, a, b);
                    else
                        send_item(dgcd_pkg::REQ_ADD, b, a);
                end
                else if (r < 16)
                    send_item(dgcd_pkg::REQ_CLEAR, rand_node(), rand_node());
                else if (r < 24)
                    send_item(dgcd_pkg::REQ_CHECK, rand_node(), rand_node());
                else
                begin
                    // in-range edge; acyclic phases point upward but for rare back edges
                    a = node_field_t'($urandom_range(1, n));
                    b = node_field_t'($urandom_range(1, n));
                    if (acyclic && a > b && $urandom_range(0, 19) != 0)
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    send_item(dgcd_pkg::REQ_ADD, a, b);
                end
                if (!steady)
                    sender_gap();
            end
            send_item(dgcd_pkg::REQ_CHECK, rand_node(), rand_node());
            if (!steady)
                sender_gap();
        end

        drain_results();
        if (sb.errors == 0)
            $display("directed_graph_cycle_detect_test: PASS");
        else
            $display("directed_graph_cycle_detect_test: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
